// ===== hw/rtl/range_max_segment_tree_core_assert.svh =====
// Assertion macros for the range maximum segment tree core
`ifndef RANGE_MAX_SEGMENT_TREE_CORE_ASSERT_SVH
`define RANGE_MAX_SEGMENT_TREE_CORE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define RMST_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define RMST_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== hw/rtl/rmst_pkg.sv =====
// Shared types and constants for the range maximum segment tree core
package rmst_pkg;

   localparam int LEAF_AW      = 10;
   localparam int NODE_AW      = LEAF_AW + 1;
   localparam int MAX_ELEMENTS = 1 << LEAF_AW;
   localparam int NODE_DEPTH   = 1 << NODE_AW;
   localparam int VAL_W        = 31;
   localparam int POS_W        = 11;
   localparam int WALK_W       = NODE_AW + 1;

   localparam logic [POS_W-1:0] COUNT_RESET = POS_W'(1024);

   typedef enum logic {
      OP_SET   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET,
      ST_QUERY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               we;
      logic [NODE_AW-1:0] addr;
      logic [VAL_W-1:0]   data;
   } ram_wr_type;

   typedef struct packed {
      logic [NODE_AW-1:0] addr_a;
      logic [NODE_AW-1:0] addr_b;
   } ram_rd_type;

   function automatic logic [VAL_W-1:0] vmax(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== hw/rtl/rmst_node_ram.sv =====
// Tree node memory: one write port, two registered read ports
module rmst_node_ram (
   input  logic                      clock,
   input  rmst_pkg::ram_wr_type      wr,
   input  rmst_pkg::ram_rd_type      rd,
   output logic [rmst_pkg::VAL_W-1:0] rd_data_a,
   output logic [rmst_pkg::VAL_W-1:0] rd_data_b
);

   logic [rmst_pkg::VAL_W-1:0] mem [rmst_pkg::NODE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd.addr_a];
      rd_data_b <= mem[rd.addr_b];
   end

endmodule

// ===== hw/rtl/range_max_segment_tree_core.sv =====
// Range maximum segment tree core: point set and range maximum query over
// positions 1..csr count (capped at 1024), kept in a 2048-word node memory.
// After reset the core runs a clearing pass, one node per cycle, before it
// takes the first item; csr writes are taken throughout. A set walks from leaf
// to root with one memory write per tree level, the sibling read overlapping
// the parent write. A query takes one step per tree level until the bounds
// meet, two node reads per step, and then folds the last reads into the result
// register. A rejected item goes straight to the done state. One item is in
// work at a time; the result register lets the next item enter while a result
// waits.
`include "range_max_segment_tree_core_assert.svh"

module range_max_segment_tree_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // position, new_value, range_low, range_high
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // range_maximum, zero pad
   output logic        rsp_tuser,  // error_flag
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data    // element_count
);

   localparam int VW = rmst_pkg::VAL_W;
   localparam int NW = rmst_pkg::NODE_AW;
   localparam int WW = rmst_pkg::WALK_W;
   localparam int PW = rmst_pkg::POS_W;

   rmst_pkg::state_type state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [PW-1:0] count_ff, count_in;
   logic [NW-1:0] node_ff, node_in;
   logic [VW-1:0] cur_ff, cur_in;
   logic [WW-1:0] lo_ff, lo_in;
   logic [WW-1:0] hi_ff, hi_in;
   logic          ra_ff, ra_in;
   logic          rb_ff, rb_in;
   logic [VW-1:0] res_max_ff, res_max_in;
   logic          res_err_ff, res_err_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_max_ff, rsp_max_in;
   logic          rsp_err_ff, rsp_err_in;

   rmst_pkg::ram_wr_type ram_wr;
   rmst_pkg::ram_rd_type ram_rd;
   logic [VW-1:0] rd_data_a;
   logic [VW-1:0] rd_data_b;

   rmst_pkg::op_type op;
   logic [PW-1:0] f_pos;
   logic [VW-1:0] f_val;
   logic [PW-1:0] f_low;
   logic [PW-1:0] f_high;
   logic [PW-1:0] live_cnt;
   logic          set_ok;
   logic          query_ok;
   logic          req_acc;
   logic          rsp_free;
   logic [NW-1:0] leaf;
   logic [NW-1:0] parent;
   logic [VW-1:0] up_max;
   logic [VW-1:0] fold_a;
   logic [VW-1:0] fold_b;
   logic [VW-1:0] fold;
   logic          walk_on;

   assign op     = rmst_pkg::op_type'(req_tuser);
   assign f_pos  = req_tdata[10:0];
   assign f_val  = req_tdata[41:11];
   assign f_low  = req_tdata[52:42];
   assign f_high = req_tdata[63:53];

   assign live_cnt = (count_ff > PW'(rmst_pkg::MAX_ELEMENTS))
                     ? PW'(rmst_pkg::MAX_ELEMENTS) : count_ff;
   assign set_ok   = (f_pos != '0) && (f_pos <= live_cnt);
   assign query_ok = (f_low != '0) && (f_low <= f_high) && (f_high <= live_cnt);
   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign leaf    = NW'(rmst_pkg::MAX_ELEMENTS) + NW'(f_pos) - NW'(1);
   assign parent  = node_ff >> 1;
   assign up_max  = rmst_pkg::vmax(cur_ff, rd_data_a);
   assign fold_a  = ra_ff ? rd_data_a : '0;
   assign fold_b  = rb_ff ? rd_data_b : '0;
   assign fold    = rmst_pkg::vmax(cur_ff, rmst_pkg::vmax(fold_a, fold_b));
   assign walk_on = lo_ff < hi_ff;

   rmst_node_ram u_ram (
      .clock     (clock),
      .wr        (ram_wr),
      .rd        (ram_rd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = rmst_pkg::ST_IDLE;
            end
         end
         rmst_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (op == rmst_pkg::OP_SET && set_ok) begin
                  state_in = rmst_pkg::ST_SET;
               end else if (op == rmst_pkg::OP_QUERY && query_ok) begin
                  state_in = rmst_pkg::ST_QUERY;
               end else begin
                  state_in = rmst_pkg::ST_DONE;
               end
            end
         end
         rmst_pkg::ST_SET: begin
            if (parent == NW'(1)) begin
               state_in = rmst_pkg::ST_DONE;
            end
         end
         rmst_pkg::ST_QUERY: begin
            if (!walk_on) begin
               state_in = rmst_pkg::ST_DONE;
            end
         end
         rmst_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = rmst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      ram_wr.we     = 1'b0;
      ram_wr.addr   = '0;
      ram_wr.data   = '0;
      ram_rd.addr_a = '0;
      ram_rd.addr_b = '0;
      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = clr_ff;
         end
         rmst_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            ram_wr.we     = req_tvalid && op == rmst_pkg::OP_SET && set_ok;
            ram_wr.addr   = leaf;
            ram_wr.data   = f_val;
            ram_rd.addr_a = leaf ^ NW'(1);
         end
         rmst_pkg::ST_SET: begin
            ram_wr.we     = 1'b1;
            ram_wr.addr   = parent;
            ram_wr.data   = up_max;
            ram_rd.addr_a = parent ^ NW'(1);
         end
         rmst_pkg::ST_QUERY: begin
            ram_rd.addr_a = lo_ff[NW-1:0];
            ram_rd.addr_b = hi_ff[NW-1:0] - NW'(1);
         end
         rmst_pkg::ST_DONE: begin
            req_tready = 1'b0;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      clr_in     = clr_ff + NW'(1);
      count_in   = (csr_valid && csr_ready) ? csr_data : count_ff;
      node_in    = node_ff;
      cur_in     = cur_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      ra_in      = 1'b0;
      rb_in      = 1'b0;
      res_max_in = res_max_ff;
      res_err_in = res_err_ff;
      case (state_ff)
         rmst_pkg::ST_IDLE: begin
            node_in    = leaf;
            cur_in     = (op == rmst_pkg::OP_SET) ? f_val : '0;
            lo_in      = WW'(rmst_pkg::MAX_ELEMENTS) + WW'(f_low) - WW'(1);
            hi_in      = WW'(rmst_pkg::MAX_ELEMENTS) + WW'(f_high);
            res_max_in = '0;
            res_err_in = (op == rmst_pkg::OP_SET) ? !set_ok : !query_ok;
         end
         rmst_pkg::ST_SET: begin
            node_in = parent;
            cur_in  = up_max;
         end
         rmst_pkg::ST_QUERY: begin
            cur_in = fold;
            if (walk_on) begin
               ra_in = lo_ff[0];
               rb_in = hi_ff[0];
               lo_in = (lo_ff + WW'(lo_ff[0])) >> 1;
               hi_in = hi_ff >> 1;
            end else begin
               res_max_in = fold;
            end
         end
         default: begin
            node_in = node_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_max_in   = rsp_max_ff;
      rsp_err_in   = rsp_err_ff;
      if (state_ff == rmst_pkg::ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_max_in   = res_max_ff;
         rsp_err_in   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= rmst_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      cur_ff     <= cur_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      res_max_ff <= res_max_in;
      res_err_ff <= res_err_in;
      rsp_max_ff <= rsp_max_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_max_ff};
   assign rsp_tuser  = rsp_err_ff;

   `RMST_ASSERT_NOW(a_err_zero_max, clock, reset, rsp_valid_ff && rsp_err_ff,
      rsp_max_ff == '0, "rejected transfer carries a nonzero maximum")
   `RMST_ASSERT_NOW(a_query_no_write, clock, reset, state_ff == rmst_pkg::ST_QUERY,
      !ram_wr.we && lo_ff <= hi_ff, "query walk wrote the tree or crossed its bounds")
   `RMST_ASSERT_NEXT(a_clear_ends, clock, reset,
      state_ff == rmst_pkg::ST_CLEAR && clr_ff == '1,
      state_ff == rmst_pkg::ST_IDLE, "clearing pass did not end after the last node")

endmodule

// ===== sim/range_max_segment_tree_core_tb.sv =====
// Self-checking testbench for the range maximum segment tree core: point sets and range queries
`timescale 1ns / 1ps

module range_max_segment_tree_core_tb;

   localparam int HALF_PERIOD = 4;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [rmst_pkg::VAL_W-1:0] VALUE_TOP = {rmst_pkg::VAL_W{1'b1}};

   typedef struct {
      logic [rmst_pkg::VAL_W-1:0] peak;
      logic                       rejected;
   } range_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // position, new_value, range_low, range_high
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // range_maximum, zero pad
   logic        rsp_tuser;        // error_flag
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [rmst_pkg::POS_W-1:0] csr_data = '0;

   logic [rmst_pkg::VAL_W-1:0] leaf_values [1:rmst_pkg::MAX_ELEMENTS];
   logic [rmst_pkg::POS_W-1:0] count_reg;
   range_result_type           pending_results [$];

   int sender_gap_pct = 0;
   int receiver_stall_pct = 0;
   int stall_hold = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int results_checked = 0;
   int sets_sent = 0;
   int queries_sent = 0;
   int rejects_seen = 0;
   int phases_run = 0;

   range_max_segment_tree_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                  cycle_count, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int live_count();
      return (count_reg > rmst_pkg::MAX_ELEMENTS) ? rmst_pkg::MAX_ELEMENTS : int'(count_reg);
   endfunction

   function automatic range_result_type apply_item(
         input rmst_pkg::op_type op,
         input logic [rmst_pkg::POS_W-1:0] pos,
         input logic [rmst_pkg::VAL_W-1:0] val,
         input logic [rmst_pkg::POS_W-1:0] lo,
         input logic [rmst_pkg::POS_W-1:0] hi);
      range_result_type res;
      int limit;
      limit = live_count();
      res.peak = '0;
      res.rejected = 1'b0;
      if (op == rmst_pkg::OP_SET) begin
         if (pos >= 1 && pos <= limit)
            leaf_values[pos] = val;
         else
            res.rejected = 1'b1;
      end else begin
         if (lo >= 1 && lo <= hi && hi <= limit) begin
            for (int p = lo; p <= hi; p++)
               if (leaf_values[p] > res.peak)
                  res.peak = leaf_values[p];
         end else begin
            res.rejected = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [rmst_pkg::VAL_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return VALUE_TOP;
         2: return rmst_pkg::VAL_W'($urandom_range(0, 255));
         default: return rmst_pkg::VAL_W'($urandom);
      endcase
   endfunction

   // receiver: long hold-off first, else random stall (always ready at zero percent)
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_tready <= 1'b0;
         stall_hold--;
      end else if (receiver_stall_pct == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      range_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual max=%0h err=%0b", $time,
                     rsp_tdata[rmst_pkg::VAL_W-1:0], rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_tdata[rmst_pkg::VAL_W-1:0] !== want.peak) begin
               mismatches++;
               $display("%0t: range_maximum expected %0h actual %0h", $time, want.peak,
                        rsp_tdata[rmst_pkg::VAL_W-1:0]);
            end
            if (rsp_tuser !== want.rejected) begin
               mismatches++;
               $display("%0t: error_flag expected %0b actual %0b", $time, want.rejected,
                        rsp_tuser);
            end
         end
      end
   end

   task automatic send_item(input rmst_pkg::op_type op,
                            input logic [rmst_pkg::POS_W-1:0] pos,
                            input logic [rmst_pkg::VAL_W-1:0] val,
                            input logic [rmst_pkg::POS_W-1:0] lo,
                            input logic [rmst_pkg::POS_W-1:0] hi);
      range_result_type res;
      @(negedge clock);
      while (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {hi, lo, val, pos};
      do @(posedge clock); while (!req_tready);
      res = apply_item(op, pos, val, lo, hi);
      pending_results.push_back(res);
      if (op == rmst_pkg::OP_SET)
         sets_sent++;
      else
         queries_sent++;
      if (res.rejected)
         rejects_seen++;
   endtask

   task automatic send_set(input logic [rmst_pkg::POS_W-1:0] pos,
                           input logic [rmst_pkg::VAL_W-1:0] val);
      send_item(rmst_pkg::OP_SET, pos, val, rmst_pkg::POS_W'($urandom),
                rmst_pkg::POS_W'($urandom));
   endtask

   task automatic send_query(input logic [rmst_pkg::POS_W-1:0] lo,
                             input logic [rmst_pkg::POS_W-1:0] hi);
      send_item(rmst_pkg::OP_QUERY, rmst_pkg::POS_W'($urandom), rmst_pkg::VAL_W'($urandom),
                lo, hi);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_count(input logic [rmst_pkg::POS_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      count_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_basics();
      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      send_query(1, 1024);
      send_set(1, VALUE_TOP);
      send_set(1024, 31'h5555_5555);
      send_set(512, 31'h2AAA_AAAA);
      send_set(0, 31'h1234_5678);
      send_set(1025, 31'h1234_5678);
      send_set(2047, VALUE_TOP);
      send_query(1, 1);
      send_query(1024, 1024);
      send_query(1, 1024);
      send_query(2, 1023);
      send_query(513, 1023);
      send_query(1000, 1000);
      send_query(0, 5);
      send_query(5, 4);
      send_query(1, 1025);
      send_query(2047, 2047);
      send_set(1, 0);
      send_query(1, 1024);
      wait_drained();
   endtask

   task automatic test_count_limits();
      write_count(0);
      send_set(1, 31'h77);
      send_query(1, 1);
      wait_drained();
      write_count(1);
      send_set(1, 31'h99);
      send_set(2, 31'h99);
      send_query(1, 1);
      send_query(1, 2);
      wait_drained();
      write_count(2047);
      send_set(1024, 31'h3333_3333);
      send_set(1025, 31'h4444_4444);
      send_query(1, 1024);
      wait_drained();
      write_count(600);
      send_query(1, 1024);
      send_query(1, 600);
      wait_drained();
      write_count(1024);
      send_query(601, 1024);
      wait_drained();
   endtask

   // hold the receiver off while the sender keeps offering
   task automatic test_backpressure();
      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      stall_hold = 300;
      for (int k = 0; k < 12; k++) begin
         if (k % 2 == 0)
            send_set(rmst_pkg::POS_W'($urandom_range(1, live_count())), rand_value());
         else
            send_query(1, rmst_pkg::POS_W'(live_count()));
      end
      wait_drained();
   endtask

   task automatic test_random_mix(input logic [rmst_pkg::POS_W-1:0] count, input int gap_pct,
                                  input int stall_pct, input int items);
      int limit;
      logic [rmst_pkg::POS_W-1:0] lo;
      logic [rmst_pkg::POS_W-1:0] hi;
      wait_drained();
      write_count(count);
      sender_gap_pct = gap_pct;
      receiver_stall_pct = stall_pct;
      limit = live_count();
      for (int k = 0; k < items; k++) begin
         if (limit == 0 || $urandom_range(0, 99) < 25) begin
            send_item(rmst_pkg::op_type'($urandom_range(0, 1)), rmst_pkg::POS_W'($urandom),
                      rmst_pkg::VAL_W'($urandom), rmst_pkg::POS_W'($urandom),
                      rmst_pkg::POS_W'($urandom));
         end else if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0: lo = 1;
               1: lo = rmst_pkg::POS_W'(limit);
               default: lo = rmst_pkg::POS_W'($urandom_range(1, limit));
            endcase
            send_set(lo, rand_value());
         end else begin
            lo = rmst_pkg::POS_W'($urandom_range(1, limit));
            if ($urandom_range(0, 2) == 0)
               hi = rmst_pkg::POS_W'($urandom_range(lo, (lo + 8 > limit) ? limit : lo + 8));
            else
               hi = rmst_pkg::POS_W'($urandom_range(lo, limit));
            send_query(lo, hi);
         end
      end
      wait_drained();
      phases_run++;
   endtask

   initial begin
      for (int p = 1; p <= rmst_pkg::MAX_ELEMENTS; p++)
         leaf_values[p] = '0;
      count_reg = rmst_pkg::COUNT_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_count_limits();
      test_backpressure();
      test_random_mix(1024, 0, 0, 300);
      test_random_mix(37, 63, 0, 300);
      test_random_mix(1024, 0, 63, 300);
      test_random_mix(2047, 25, 25, 300);
      test_random_mix(1, 25, 25, 80);
      test_random_mix(700, 0, 0, 220);
      test_backpressure();

      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      wait_drained();
      repeat (40) @(posedge clock);

      $display("Covered %0d sets and %0d queries (%0d rejected) over %0d random phases,",
               sets_sent, queries_sent, rejects_seen, phases_run);
      $display("counts 0 to 2047, long receiver hold-offs; %0d results checked.",
               results_checked);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
